// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DRS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/drs_pkg.sv =====
// Package for the disk request scheduler: sizes, codes, FSM states,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package drs_pkg;
  localparam int MAX_REQ  = 16;
  localparam int CYL_BITS = 16;
  localparam int IDX_W    = $clog2(MAX_REQ);
  localparam int CNT_W    = 5;
  localparam int MOVE_W   = 20;
  localparam int CC_W     = 17;
  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    POL_FCFS  = 3'd0,
    POL_SSTF  = 3'd1,
    POL_SCAN  = 3'd2,
    POL_CSCAN = 3'd3,
    POL_LOOK  = 3'd4,
    POL_CLOOK = 3'd5
  } policy_t;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_CYL_COUNT = 2'd1,
    REG_START = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SEARCH, ST_RESOLVE, ST_PICK, ST_STOP, ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic run_init;
    logic search_init;
    logic search_step;
    logic phase_adv;
    logic emit_pick;
    logic emit_stop;
    logic emit_start;
  } drs_cmd_t;

  typedef struct packed {
    logic pol_ok;
    logic list_pol;   // fcfs or sstf
    logic stop_pol;   // scan or cscan
    logic i_end;
    logic n_zero;
    logic scan_last;
    logic found;
    logic phase;
    logic k_zero;
    logic out_free;
  } drs_sts_t;

  function automatic logic [MOVE_W-1:0] sat_add(input logic [MOVE_W-1:0] a,
                                                input logic [17:0] d);
    logic [MOVE_W:0] s;
    s = {1'b0, a} + {{(MOVE_W-17){1'b0}}, d};
    sat_add = (s > {1'b0, MOVE_MAX}) ? MOVE_MAX : s[MOVE_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/drs_ctrl.sv =====
// Sequencer for the scheduler: issues loads and clears, walks the search, pick, stop and final steps of a run.
// Depends on drs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module drs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_command,
  output logic                  in_stall,
  input  drs_pkg::drs_sts_t     sts,
  output drs_pkg::drs_cmd_t     cmd
);
  import drs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_LOAD:  cmd.load = 1'b1;
            CMD_CLEAR: cmd.clear = 1'b1;
            CMD_RUN: begin
              if (sts.pol_ok) begin
                cmd.run_init = 1'b1;
                state_nxt    = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.list_pol && sts.i_end) begin
          state_nxt = sts.k_zero ? ST_FINAL : ST_IDLE;
        end else begin
          cmd.search_init = 1'b1;
          state_nxt       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!sts.n_zero) cmd.search_step = 1'b1;
        if (sts.n_zero || sts.scan_last) state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (sts.found) begin
          state_nxt = ST_PICK;
        end else if (!sts.phase) begin
          if (sts.stop_pol) begin
            state_nxt = ST_STOP;
          end else begin
            cmd.phase_adv = 1'b1;
            state_nxt     = ST_CHECK;
          end
        end else begin
          state_nxt = sts.k_zero ? ST_FINAL : ST_IDLE;
        end
      end
      ST_PICK: begin
        if (sts.out_free) begin
          cmd.emit_pick = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_STOP: begin
        if (sts.out_free) begin
          cmd.emit_stop = 1'b1;
          cmd.phase_adv = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `DRS_ASSERT_IMP(a_emit_slot, cmd.emit_pick || cmd.emit_stop || cmd.emit_start, sts.out_free, "emit without free output slot")
endmodule
`default_nettype wire

// ===== sv/drs_dp.sv =====
// Datapath: config registers, request store, work list, search unit,
// head/movement tracking and output register. Depends on drs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module drs_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [drs_pkg::CC_W-1:0]        cfg_data,
  input  wire logic [drs_pkg::CYL_BITS-1:0]    in_cylinder,
  input  drs_pkg::drs_cmd_t                    cmd,
  output drs_pkg::drs_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [15:0]                          out_served_cylinder,
  output logic [4:0]                           out_step_index,
  output logic [19:0]                          out_total_movement,
  output logic                                 out_last
);
  import drs_pkg::*;

  logic [2:0]          policy_r;
  logic [CC_W-1:0]     cc_r;
  logic [CYL_BITS-1:0] start_r;

  logic [CYL_BITS-1:0] store_r [MAX_REQ];
  logic [CYL_BITS-1:0] work_r  [MAX_REQ];
  logic [MAX_REQ-1:0]  used_r;
  logic [CNT_W-1:0]    total_r, i_r, j_r, k_r, kmax_r;
  logic [CYL_BITS-1:0] head_r, best_val_r, wi_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [CYL_BITS-1:0] best_key_r;
  logic                found_r, phase_r;
  logic [MOVE_W-1:0]   move_r;

  logic                out_valid_r, out_last_r;
  logic [15:0]         out_cyl_r;
  logic [4:0]          out_step_r;
  logic [19:0]         out_move_r;

  logic is_fcfs, is_sstf, is_scan, is_cscan, is_look, is_clook;
  assign is_fcfs  = (policy_r == POL_FCFS);
  assign is_sstf  = (policy_r == POL_SSTF);
  assign is_scan  = (policy_r == POL_SCAN);
  assign is_cscan = (policy_r == POL_CSCAN);
  assign is_look  = (policy_r == POL_LOOK);
  assign is_clook = (policy_r == POL_CLOOK);

  logic list_pol, stop_pol;
  assign list_pol = is_fcfs || is_sstf;
  assign stop_pol = is_scan || is_cscan;

  // search unit: one work-list entry per cycle
  logic [CYL_BITS-1:0] v, key, dv;
  logic below, elig, take;
  logic [IDX_W-1:0] jx;
  assign jx    = j_r[IDX_W-1:0];
  assign v     = work_r[jx];
  assign below = (v < start_r);
  assign dv    = (v > head_r) ? v - head_r : head_r - v;

  always_comb begin
    elig = 1'b0;
    key  = '0;
    if (is_fcfs) begin
      elig = 1'b1;
    end else if (is_sstf) begin
      elig = 1'b1;
      key  = dv;
    end else if ((is_scan || is_look) && !phase_r) begin
      elig = !used_r[jx] && below;
      key  = ~v;
    end else if ((is_cscan || is_clook) && phase_r) begin
      elig = !used_r[jx] && below;
      key  = v;
    end else begin
      elig = !used_r[jx] && !below;
      key  = v;
    end
  end
  assign take = elig && (!found_r || (key < best_key_r));

  // movement terms
  logic [CYL_BITS-1:0] dpick;
  logic [CC_W-1:0]     top;
  logic [CC_W-1:0]     dtop;
  logic [17:0]         dstop;
  logic [MOVE_W-1:0]   move_pick, move_stop;
  assign dpick = (best_val_r > head_r) ? best_val_r - head_r : head_r - best_val_r;
  assign top   = (cc_r == '0) ? '0 : cc_r - 1'b1;
  assign dtop  = (top > {1'b0, head_r}) ? top - {1'b0, head_r} : {1'b0, head_r} - top;
  assign dstop = is_cscan ? ({1'b0, dtop} + {1'b0, cc_r}) : {2'b00, head_r};
  assign move_pick = sat_add(move_r, {2'b00, dpick});
  assign move_stop = sat_add(move_r, dstop);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic [CNT_W-1:0] kcount;
  assign kcount = total_r + {{(CNT_W-1){1'b0}}, stop_pol};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FCFS;
      cc_r        <= 17'h10000;
      start_r     <= '0;
      total_r     <= '0;
      head_r      <= '0;
      move_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      phase_r     <= 1'b0;
      used_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kmax_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:    policy_r <= cfg_data[2:0];
          REG_CYL_COUNT: cc_r     <= cfg_data;
          REG_START:     start_r  <= cfg_data[CYL_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.load && (total_r < CNT_W'(MAX_REQ)) && ({1'b0, in_cylinder} < cc_r)) begin
        store_r[total_r[IDX_W-1:0]] <= in_cylinder;
        total_r <= total_r + 1'b1;
      end
      if (cmd.clear) total_r <= '0;

      if (cmd.run_init) begin
        for (int e = 0; e < MAX_REQ; e++) work_r[e] <= store_r[e];
        used_r  <= '0;
        head_r  <= start_r;
        move_r  <= '0;
        i_r     <= '0;
        k_r     <= '0;
        phase_r <= 1'b0;
        kmax_r  <= (kcount == '0) ? '0 : kcount - 1'b1;
      end
      if (cmd.search_init) begin
        j_r     <= list_pol ? i_r : '0;
        found_r <= 1'b0;
      end
      if (cmd.search_step) begin
        if (take) begin
          found_r    <= 1'b1;
          best_idx_r <= jx;
          best_val_r <= v;
          best_key_r <= key;
        end
        if (j_r == i_r) wi_r <= v;
        j_r <= j_r + 1'b1;
      end
      if (cmd.phase_adv) phase_r <= 1'b1;

      if (cmd.emit_pick) begin
        head_r <= best_val_r;
        move_r <= move_pick;
        used_r[best_idx_r] <= 1'b1;
        if (is_sstf) begin
          if (best_idx_r != i_r[IDX_W-1:0]) work_r[best_idx_r] <= wi_r;
          work_r[i_r[IDX_W-1:0]] <= best_val_r;
        end
        i_r <= i_r + 1'b1;
      end
      if (cmd.emit_stop) begin
        head_r <= '0;
        move_r <= move_stop;
      end
      if (cmd.emit_pick || cmd.emit_stop || cmd.emit_start) begin
        out_valid_r <= 1'b1;
        k_r         <= k_r + 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_pick) begin
      out_cyl_r  <= best_val_r;
      out_move_r <= move_pick;
    end else if (cmd.emit_stop) begin
      out_cyl_r  <= '0;
      out_move_r <= move_stop;
    end else if (cmd.emit_start) begin
      out_cyl_r  <= head_r;
      out_move_r <= move_r;
    end
    if (cmd.emit_pick || cmd.emit_stop || cmd.emit_start) begin
      out_step_r <= k_r;
      out_last_r <= (k_r == kmax_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_served_cylinder = out_cyl_r;
  assign out_step_index      = out_step_r;
  assign out_total_movement  = out_move_r;
  assign out_last            = out_last_r;

  assign sts.pol_ok    = (policy_r <= POL_CLOOK);
  assign sts.list_pol  = list_pol;
  assign sts.stop_pol  = stop_pol;
  assign sts.i_end     = (i_r == total_r);
  assign sts.n_zero    = (total_r == '0);
  assign sts.scan_last = is_fcfs || (j_r == total_r - 1'b1);
  assign sts.found     = found_r;
  assign sts.phase     = phase_r;
  assign sts.k_zero    = (k_r == '0);
  assign sts.out_free  = out_free;

  `DRS_ASSERT_NXT(a_move_mono, !cmd.run_init, move_r >= $past(move_r), "movement went backward within a run")
  `DRS_ASSERT_IMP(a_last_step, cmd.emit_pick || cmd.emit_stop || cmd.emit_start, k_r <= kmax_r, "step past last")
endmodule
`default_nettype wire

// ===== sv/disk_request_scheduler.sv =====
// Disk request scheduler, top level: ties the sequencer to the datapath.
// Depends on drs_pkg, drs_ctrl, drs_dp.
//
// Usage: configure policy, cylinder count and start cylinder on the cfg
// write port while idle. Send items on in_* (valid/stall): command 0 loads
// a request (dropped if the store holds 16 or the cylinder is out of range),
// 2 clears the store, 1 runs the schedule. A run emits one item per visit
// on out_*, with step index, accumulated movement and last on the final
// item; SCAN and C-SCAN add a stop item at cylinder 0, and a run with no
// other item emits the start cylinder. Each visit is one search pass (one
// entry per cycle) over all n requests for the sweeps, the unserved tail
// for SSTF, the next entry for FCFS. in_stall stays high for the whole run.
// A stalled result holds in the output register; the next one waits until
// it is taken. Synchronous reset empties the store, drops any pending result
// and restores policy FCFS, 65536 cylinders and start cylinder 0.
`default_nettype none
module disk_request_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_cylinder,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_served_cylinder,
  output logic [4:0]       out_step_index,
  output logic [19:0]      out_total_movement,
  output logic             out_last
);
  import drs_pkg::*;

  drs_cmd_t cmd;
  drs_sts_t sts;

  drs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  drs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_cylinder         (in_cylinder),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_served_cylinder (out_served_cylinder),
    .out_step_index      (out_step_index),
    .out_total_movement  (out_total_movement),
    .out_last            (out_last)
  );
endmodule
`default_nettype wire
